FILE: src/stt_pkg.sv
// Shared types, token kinds and keyword tables of the source text tokenizer.
package stt_pkg;

    // Scan mode: what kind of token is being held open.
    typedef enum logic [11:0] {
        M_IDLE    = 12'b0000_0000_0001,
        M_STAR    = 12'b0000_0000_0010,
        M_GREATER = 12'b0000_0000_0100,
        M_LESS    = 12'b0000_0000_1000,
        M_EQUAL   = 12'b0000_0001_0000,
        M_AMP     = 12'b0000_0010_0000,
        M_PIPE    = 12'b0000_0100_0000,
        M_BANG    = 12'b0000_1000_0000,
        M_INT     = 12'b0001_0000_0000,
        M_DEC     = 12'b0010_0000_0000,
        M_IDENT   = 12'b0100_0000_0000,
        M_STRING  = 12'b1000_0000_0000
    } t_mode;

    typedef logic [5:0] t_kind;

    // Token kinds
    localparam t_kind K_LPAREN   = 6'd0;
    localparam t_kind K_RPAREN   = 6'd1;
    localparam t_kind K_LBRACKET = 6'd2;
    localparam t_kind K_RBRACKET = 6'd3;
    localparam t_kind K_LBRACE   = 6'd4;
    localparam t_kind K_RBRACE   = 6'd5;
    localparam t_kind K_SEMI     = 6'd6;
    localparam t_kind K_COLON    = 6'd7;
    localparam t_kind K_DOT      = 6'd8;
    localparam t_kind K_COMMA    = 6'd9;
    localparam t_kind K_PLUS     = 6'd10;
    localparam t_kind K_MINUS    = 6'd11;
    localparam t_kind K_STAR     = 6'd12;
    localparam t_kind K_POW      = 6'd13;
    localparam t_kind K_SLASH    = 6'd14;
    localparam t_kind K_GT       = 6'd15;
    localparam t_kind K_SHR      = 6'd16;
    localparam t_kind K_GE       = 6'd17;
    localparam t_kind K_LT       = 6'd18;
    localparam t_kind K_SHL      = 6'd19;
    localparam t_kind K_LE       = 6'd20;
    localparam t_kind K_ASSIGN   = 6'd21;
    localparam t_kind K_EQ       = 6'd22;
    localparam t_kind K_AMP      = 6'd23;
    localparam t_kind K_LAND     = 6'd24;
    localparam t_kind K_PIPE     = 6'd25;
    localparam t_kind K_LOR      = 6'd26;
    localparam t_kind K_TILDE    = 6'd27;
    localparam t_kind K_BANG     = 6'd28;
    localparam t_kind K_NE       = 6'd29;
    localparam t_kind K_CARET    = 6'd30;
    localparam t_kind K_STRING   = 6'd31;
    localparam t_kind K_INTEGER  = 6'd32;
    localparam t_kind K_DECIMAL  = 6'd33;
    localparam t_kind K_IDENT    = 6'd34;
    localparam t_kind K_LET      = 6'd35;  // first of the ten keywords
    localparam t_kind K_ERROR    = 6'd45;
    localparam t_kind K_END      = 6'd46;

    localparam int NUM_KW = 10;

    // Keywords, left-justified in 8 bytes
    localparam logic [63:0] KW_WORD [NUM_KW] = '{
        {"let", 40'd0}, {"return", 16'd0}, {"function"}, {"if", 48'd0},
        {"else", 32'd0}, {"while", 24'd0}, {"for", 40'd0}, {"in", 48'd0},
        {"continue"}, {"break", 24'd0}
    };
    localparam logic [3:0] KW_LEN [NUM_KW] = '{
        4'd3, 4'd6, 4'd8, 4'd2, 4'd4, 4'd5, 4'd3, 4'd2, 4'd8, 4'd5
    };

    // One result token
    typedef struct packed {
        logic        last;
        logic [15:0] line;
        logic [15:0] length;
        logic [15:0] start;
        t_kind       kind;
    } t_token;

    // Byte j of keyword k
    function automatic logic [7:0] kw_byte(input logic [63:0] word, input logic [2:0] j);
        kw_byte = word[{~j, 3'b000} +: 8];
    endfunction

endpackage

FILE: src/source_text_tokenizer_core.sv
// Streaming lexical scanner: source bytes in, tokens out.
// A token caused by a byte is written into the result queue when the byte is accepted;
// bytes are taken one per cycle while no more than two tokens wait in the 4-entry result
// queue. A byte that yields two tokens writes both into the queue together.
// Reset (synchronous, active low) returns the scanner to idle, offset 0, line 1, and
// empties the result queue.
module source_text_tokenizer_core #(
    parameter int OFFSET_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] ch
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // [5:0] token_kind, [21:6] token_start,
                                        // [37:22] token_length, [53:38] line_number
    output logic        m_axis_tlast    // last
);

    localparam int LW = (OFFSET_BITS > 16) ? OFFSET_BITS : 16;
    localparam logic [LW-1:0] LEN_MAX = LW'(16'hFFFF);
    localparam logic [7:0] CH_CR = 8'h0D;

    // Scanner state
    stt_pkg::t_mode         r_mode, n_mode;
    logic [OFFSET_BITS-1:0] r_pos, n_pos;
    logic [OFFSET_BITS-1:0] r_begin, n_begin;
    logic [15:0]            r_line, n_line;
    logic [9:0]             r_cand, n_cand;

    // Result queue
    stt_pkg::t_token r_fifo [4];
    logic [1:0]      r_wr, r_rd;
    logic [2:0]      r_count, n_count;

    logic            in_acc, out_acc;
    logic [7:0]      c;
    logic            pos_sat;
    logic [OFFSET_BITS-1:0] end_incl;
    logic            v1, v1b, v2, consumed, ended;
    stt_pkg::t_token t1, t1b, t2, slot0, slot1;
    logic [1:0]      wcnt;

    // Token fields from kind, start and one-past-end offset
    function automatic stt_pkg::t_token make_tok(input stt_pkg::t_kind kind,
                                                 input logic [OFFSET_BITS-1:0] start,
                                                 input logic [OFFSET_BITS-1:0] fin,
                                                 input logic [15:0] line);
        logic [LW-1:0] len_ext;
        logic [LW-1:0] start_ext;
        len_ext   = LW'(fin - start);
        start_ext = LW'(start);
        make_tok.kind   = kind;
        make_tok.start  = start_ext[15:0];
        make_tok.length = (len_ext > LEN_MAX) ? 16'hFFFF : len_ext[15:0];
        make_tok.line   = line;
        make_tok.last   = 1'b0;
    endfunction

    // Drop keywords that the byte at offset idx of the identifier no longer matches
    function automatic logic [9:0] filt(input logic [9:0] cand,
                                        input logic [OFFSET_BITS-1:0] idx,
                                        input logic [7:0] ch, input logic sat);
        logic near;
        near = (idx < OFFSET_BITS'(8));
        filt = cand;
        for (int i = 0; i < stt_pkg::NUM_KW; i++) begin
            if (sat || !near || ({1'b0, idx[2:0]} >= stt_pkg::KW_LEN[i]) ||
                (stt_pkg::kw_byte(stt_pkg::KW_WORD[i], idx[2:0]) != ch))
                filt[i] = 1'b0;
        end
    endfunction

    function automatic logic is_digit(input logic [7:0] ch);
        is_digit = (ch >= "0") && (ch <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] ch);
        is_alpha = ((ch >= "A") && (ch <= "Z")) || ((ch >= "a") && (ch <= "z")) ||
                   (ch == "_");
    endfunction

    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_acc       = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (r_count < 3'd3);
    assign c             = s_axis_tdata;
    assign pos_sat       = &r_pos;
    assign end_incl      = pos_sat ? r_pos : r_pos + OFFSET_BITS'(1);

    // Scan step: close the held token, then treat the byte from idle if it is left over
    always_comb begin
        logic [7:0]            sec, sec_b;
        logic                  has_b, op_mode;
        stt_pkg::t_kind        k2, k2b, k1, ik;
        logic [OFFSET_BITS-1:0] ilen;

        n_mode   = r_mode;
        n_pos    = r_pos;
        n_begin  = r_begin;
        n_line   = r_line;
        n_cand   = r_cand;
        v1       = 1'b0;
        v1b      = 1'b0;
        v2       = 1'b0;
        t1       = '0;
        t1b      = '0;
        t2       = '0;
        consumed = 1'b0;
        ended    = 1'b0;
        sec      = 8'd0;
        sec_b    = 8'd0;
        has_b    = 1'b0;
        op_mode  = 1'b0;
        k2       = stt_pkg::K_ERROR;
        k2b      = stt_pkg::K_ERROR;
        k1       = stt_pkg::K_ERROR;

        // keyword lookup for a finished identifier
        ilen = r_pos - r_begin;
        ik   = stt_pkg::K_IDENT;
        for (int i = stt_pkg::NUM_KW - 1; i >= 0; i--) begin
            if (r_cand[i] && (ilen == OFFSET_BITS'(stt_pkg::KW_LEN[i])))
                ik = stt_pkg::K_LET + 6'(i);
        end

        // held token
        case (r_mode)
            stt_pkg::M_IDLE: begin
            end
            stt_pkg::M_STAR: begin
                op_mode = 1'b1; sec = "*"; k2 = stt_pkg::K_POW; k1 = stt_pkg::K_STAR;
            end
            stt_pkg::M_GREATER: begin
                op_mode = 1'b1; sec = ">"; k2 = stt_pkg::K_SHR; k1 = stt_pkg::K_GT;
                has_b = 1'b1; sec_b = "="; k2b = stt_pkg::K_GE;
            end
            stt_pkg::M_LESS: begin
                op_mode = 1'b1; sec = "<"; k2 = stt_pkg::K_SHL; k1 = stt_pkg::K_LT;
                has_b = 1'b1; sec_b = "="; k2b = stt_pkg::K_LE;
            end
            stt_pkg::M_EQUAL: begin
                op_mode = 1'b1; sec = "="; k2 = stt_pkg::K_EQ; k1 = stt_pkg::K_ASSIGN;
            end
            stt_pkg::M_AMP: begin
                op_mode = 1'b1; sec = "&"; k2 = stt_pkg::K_LAND; k1 = stt_pkg::K_AMP;
            end
            stt_pkg::M_PIPE: begin
                op_mode = 1'b1; sec = "|"; k2 = stt_pkg::K_LOR; k1 = stt_pkg::K_PIPE;
            end
            stt_pkg::M_BANG: begin
                op_mode = 1'b1; sec = "="; k2 = stt_pkg::K_NE; k1 = stt_pkg::K_BANG;
            end
            stt_pkg::M_INT: begin
                if (is_digit(c)) begin
                    consumed = 1'b1;
                end else if (c == ".") begin
                    n_mode   = stt_pkg::M_DEC;
                    consumed = 1'b1;
                end else begin
                    v1     = 1'b1;
                    t1     = make_tok(stt_pkg::K_INTEGER, r_begin, r_pos, r_line);
                    n_mode = stt_pkg::M_IDLE;
                end
            end
            stt_pkg::M_DEC: begin
                if (is_digit(c)) begin
                    consumed = 1'b1;
                end else begin
                    v1     = 1'b1;
                    t1     = make_tok(stt_pkg::K_DECIMAL, r_begin, r_pos, r_line);
                    n_mode = stt_pkg::M_IDLE;
                end
            end
            stt_pkg::M_IDENT: begin
                if (is_alpha(c) || is_digit(c)) begin
                    n_cand   = filt(r_cand, r_pos - r_begin, c, pos_sat);
                    consumed = 1'b1;
                end else begin
                    v1     = 1'b1;
                    t1     = make_tok(ik, r_begin, r_pos, r_line);
                    n_cand = '1;
                    n_mode = stt_pkg::M_IDLE;
                end
            end
            stt_pkg::M_STRING: begin
                consumed = 1'b1;
                if (c == "\"") begin
                    v1     = 1'b1;
                    t1     = make_tok(stt_pkg::K_STRING, r_begin, end_incl, r_line);
                    n_mode = stt_pkg::M_IDLE;
                end else if (c == 8'd0) begin
                    // unterminated string: error, then end of source
                    v1    = 1'b1;
                    t1    = make_tok(stt_pkg::K_ERROR, r_begin, r_pos, r_line);
                    v1b   = 1'b1;
                    t1b   = make_tok(stt_pkg::K_END, r_pos, end_incl, r_line);
                    ended = 1'b1;
                end
            end
            default: begin
                n_mode = stt_pkg::M_IDLE;
            end
        endcase

        // operator that may take a second byte
        if (op_mode) begin
            n_mode = stt_pkg::M_IDLE;
            v1     = 1'b1;
            if (c == sec) begin
                t1       = make_tok(k2, r_begin, end_incl, r_line);
                consumed = 1'b1;
            end else if (has_b && (c == sec_b)) begin
                t1       = make_tok(k2b, r_begin, end_incl, r_line);
                consumed = 1'b1;
            end else begin
                t1 = make_tok(k1, r_begin, r_pos, r_line);
            end
        end

        // byte seen with nothing held
        if (!consumed) begin
            case (c)
                " ", "\t", CH_CR, "\n": begin
                end
                8'd0: begin
                    v2    = 1'b1;
                    t2    = make_tok(stt_pkg::K_END, r_pos, end_incl, r_line);
                    ended = 1'b1;
                end
                "*": begin n_mode = stt_pkg::M_STAR;    n_begin = r_pos; end
                ">": begin n_mode = stt_pkg::M_GREATER; n_begin = r_pos; end
                "<": begin n_mode = stt_pkg::M_LESS;    n_begin = r_pos; end
                "=": begin n_mode = stt_pkg::M_EQUAL;   n_begin = r_pos; end
                "&": begin n_mode = stt_pkg::M_AMP;     n_begin = r_pos; end
                "|": begin n_mode = stt_pkg::M_PIPE;    n_begin = r_pos; end
                "!": begin n_mode = stt_pkg::M_BANG;    n_begin = r_pos; end
                "\"": begin n_mode = stt_pkg::M_STRING; n_begin = r_pos; end
                "(": begin v2 = 1'b1; t2 = make_tok(stt_pkg::K_LPAREN, r_pos, end_incl, r_line); end
                ")": begin v2 = 1'b1; t2 = make_tok(stt_pkg::K_RPAREN, r_pos, end_incl, r_line); end
                "[": begin v2 = 1'b1; t2 = make_tok(stt_pkg::K_LBRACKET, r_pos, end_incl, r_line); end
                "]": begin v2 = 1'b1; t2 = make_tok(stt_pkg::K_RBRACKET, r_pos, end_incl, r_line); end
                "{": begin v2 = 1'b1; t2 = make_tok(stt_pkg::K_LBRACE, r_pos, end_incl, r_line); end
                "}": begin v2 = 1'b1; t2 = make_tok(stt_pkg::K_RBRACE, r_pos, end_incl, r_line); end
                ";": begin v2 = 1'b1; t2 = make_tok(stt_pkg::K_SEMI, r_pos, end_incl, r_line); end
                ":": begin v2 = 1'b1; t2 = make_tok(stt_pkg::K_COLON, r_pos, end_incl, r_line); end
                ".": begin v2 = 1'b1; t2 = make_tok(stt_pkg::K_DOT, r_pos, end_incl, r_line); end
                ",": begin v2 = 1'b1; t2 = make_tok(stt_pkg::K_COMMA, r_pos, end_incl, r_line); end
                "+": begin v2 = 1'b1; t2 = make_tok(stt_pkg::K_PLUS, r_pos, end_incl, r_line); end
                "-": begin v2 = 1'b1; t2 = make_tok(stt_pkg::K_MINUS, r_pos, end_incl, r_line); end
                "/": begin v2 = 1'b1; t2 = make_tok(stt_pkg::K_SLASH, r_pos, end_incl, r_line); end
                "~": begin v2 = 1'b1; t2 = make_tok(stt_pkg::K_TILDE, r_pos, end_incl, r_line); end
                "^": begin v2 = 1'b1; t2 = make_tok(stt_pkg::K_CARET, r_pos, end_incl, r_line); end
                default: begin
                    if (is_digit(c)) begin
                        n_mode  = stt_pkg::M_INT;
                        n_begin = r_pos;
                    end else if (is_alpha(c)) begin
                        n_mode  = stt_pkg::M_IDENT;
                        n_begin = r_pos;
                        n_cand  = filt('1, '0, c, pos_sat);
                    end else begin
                        v2 = 1'b1;
                        t2 = make_tok(stt_pkg::K_ERROR, r_pos, end_incl, r_line);
                    end
                end
            endcase
        end

        // advance offset and line, or start over after the end token
        if (ended) begin
            n_mode  = stt_pkg::M_IDLE;
            n_pos   = '0;
            n_begin = '0;
            n_line  = 16'd1;
            n_cand  = '1;
        end else begin
            if ((c == "\n") && (r_line != 16'hFFFF))
                n_line = r_line + 16'd1;
            if (!pos_sat)
                n_pos = r_pos + OFFSET_BITS'(1);
        end
    end

    // Order the tokens of this byte and mark the final one
    always_comb begin
        slot0 = v1 ? t1 : t2;
        slot1 = v1b ? t1b : t2;
        wcnt  = 2'(v1) + 2'(v1b) + 2'(v2);
        if (wcnt == 2'd1)
            slot0.last = 1'b1;
        slot1.last = 1'b1;
    end

    assign n_count = r_count + (in_acc ? {1'b0, wcnt} : 3'd0) - 3'(out_acc);

    // Scanner state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= stt_pkg::M_IDLE;
            r_pos   <= '0;
            r_begin <= '0;
            r_line  <= 16'd1;
            r_cand  <= '1;
        end else if (in_acc) begin
            r_mode  <= n_mode;
            r_pos   <= n_pos;
            r_begin <= n_begin;
            r_line  <= n_line;
            r_cand  <= n_cand;
        end
    end

    // Result queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (in_acc)
                r_wr <= r_wr + wcnt;
            if (out_acc)
                r_rd <= r_rd + 2'd1;
        end
    end

    // Result queue storage
    always_ff @(posedge i_clk) begin
        if (in_acc && (wcnt != 2'd0))
            r_fifo[r_wr] <= slot0;
        if (in_acc && (wcnt == 2'd2))
            r_fifo[r_wr + 2'd1] <= slot1;
    end

    // Output side
    always_comb begin
        stt_pkg::t_token head;
        head          = r_fifo[r_rd];
        m_axis_tvalid = (r_count != 3'd0);
        m_axis_tdata  = {2'b00, head.line, head.length, head.start, head.kind};
        m_axis_tlast  = head.last;
    end

endmodule

FILE: src/stt_checker.sv
// Port-level checks for the tokenizer core, bound into the core module.
module stt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [7:0]  s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // Nothing is shown straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("token shown after reset");

    // A stalled token stays offered
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("token withdrawn while stalled");

    // Line number never drops to zero
    a_line_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[53:38] != 16'd0)
        else $error("zero line number");

    // Kind stays within the defined codes
    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[5:0] <= stt_pkg::K_END && m_axis_tdata[55:54] == 2'b00)
        else $error("bad token kind or padding");

    // An end-of-source token is always the final token of its byte
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[5:0] == stt_pkg::K_END |-> m_axis_tlast)
        else $error("end token not marked last");

endmodule

bind source_text_tokenizer_core stt_checker u_stt_checker (.*);

FILE: test/source_text_tokenizer_core_checker.sv
// Channel monitor and token predictor for the source text tokenizer testbench.
module source_text_tokenizer_core_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,     // [7:0] ch
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [55:0] i_m_tdata,     // [5:0] kind, [21:6] start, [37:22] length,
                                       // [53:38] line
    input  logic        i_m_tlast,     // last
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned POS_MAX  = 65535;   // offsets are 16 bits wide
    localparam int unsigned LINE_MAX = 65535;
    localparam int          PRINT_CAP = 100;

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;

    string kw_spelling [10] = '{"let", "return", "function", "if", "else",
                                "while", "for", "in", "continue", "break"};

    // Predicted scanner state
    stt_pkg::t_mode scan_mode;
    int unsigned    cur_pos;
    int unsigned    tok_begin;
    int unsigned    line_cnt;
    logic [9:0]     kw_cands;

    stt_pkg::t_token due_tokens [$];   // tokens the block still owes
    stt_pkg::t_token step_tokens [$];  // tokens caused by the byte in hand
    int              fail_total = 0;
    int              tokens_seen = 0;

    task automatic report_mismatch(input string msg);
        if (fail_total < PRINT_CAP)
            $display("%0t checker: %s", $time, msg);
        fail_total++;
    endtask

    function automatic void reset_scanner();
        scan_mode = stt_pkg::M_IDLE;
        cur_pos   = 0;
        tok_begin = 0;
        line_cnt  = 1;
        kw_cands  = '1;
    endfunction

    // Offset just past the current byte, held at the top
    function automatic int unsigned next_end();
        return (cur_pos < POS_MAX) ? cur_pos + 1 : POS_MAX;
    endfunction

    function automatic void push_token(input stt_pkg::t_kind k, input int unsigned from,
                                       input int unsigned upto);
        stt_pkg::t_token t;
        int unsigned     len;
        len = (upto >= from) ? upto - from : 0;
        if (len > 65535)
            len = 65535;
        t.kind   = k;
        t.start  = from[15:0];
        t.length = len[15:0];
        t.line   = line_cnt[15:0];
        t.last   = 1'b0;
        if (step_tokens.size() < 2)
            step_tokens.push_back(t);
    endfunction

    function automatic void hold(input stt_pkg::t_mode m);
        scan_mode = m;
        tok_begin = cur_pos;
    endfunction

    // Drop keywords whose spelling no longer matches the identifier so far
    function automatic void narrow_keywords(input logic [7:0] c);
        int unsigned idx;
        idx = cur_pos - tok_begin;
        if (cur_pos >= POS_MAX) begin
            kw_cands = '0;
            return;
        end
        for (int i = 0; i < 10; i++) begin
            if (idx >= kw_spelling[i].len() || kw_spelling[i][idx] != c)
                kw_cands[i] = 1'b0;
        end
    endfunction

    function automatic stt_pkg::t_kind identifier_kind();
        int unsigned len;
        len = cur_pos - tok_begin;
        for (int i = 0; i < 10; i++) begin
            if (kw_cands[i] && kw_spelling[i].len() == len)
                return stt_pkg::t_kind'(stt_pkg::K_LET + i);
        end
        return stt_pkg::K_IDENT;
    endfunction

    // Operator that may pair with the next byte; 1 when the byte is used up
    function automatic bit close_operator(input logic [7:0] c, input logic [7:0] second,
                                          input stt_pkg::t_kind pair_kind,
                                          input logic [7:0] alt,
                                          input stt_pkg::t_kind alt_kind,
                                          input stt_pkg::t_kind single_kind);
        scan_mode = stt_pkg::M_IDLE;
        if (c == second) begin
            push_token(pair_kind, tok_begin, next_end());
            return 1'b1;
        end
        if (alt != CH_NUL && c == alt) begin
            push_token(alt_kind, tok_begin, next_end());
            return 1'b1;
        end
        push_token(single_kind, tok_begin, cur_pos);
        return 1'b0;
    endfunction

    // Byte seen with nothing held; 1 when it ends the source
    function automatic bit scan_idle(input logic [7:0] c);
        if (c == " " || c == CH_TAB || c == CH_CR || c == CH_LF)
            return 1'b0;
        if (c == CH_NUL) begin
            push_token(stt_pkg::K_END, cur_pos, next_end());
            return 1'b1;
        end
        case (c)
            "*": hold(stt_pkg::M_STAR);
            ">": hold(stt_pkg::M_GREATER);
            "<": hold(stt_pkg::M_LESS);
            "=": hold(stt_pkg::M_EQUAL);
            "&": hold(stt_pkg::M_AMP);
            "|": hold(stt_pkg::M_PIPE);
            "!": hold(stt_pkg::M_BANG);
            "\"": hold(stt_pkg::M_STRING);
            "(": push_token(stt_pkg::K_LPAREN, cur_pos, next_end());
            ")": push_token(stt_pkg::K_RPAREN, cur_pos, next_end());
            "[": push_token(stt_pkg::K_LBRACKET, cur_pos, next_end());
            "]": push_token(stt_pkg::K_RBRACKET, cur_pos, next_end());
            "{": push_token(stt_pkg::K_LBRACE, cur_pos, next_end());
            "}": push_token(stt_pkg::K_RBRACE, cur_pos, next_end());
            ";": push_token(stt_pkg::K_SEMI, cur_pos, next_end());
            ":": push_token(stt_pkg::K_COLON, cur_pos, next_end());
            ".": push_token(stt_pkg::K_DOT, cur_pos, next_end());
            ",": push_token(stt_pkg::K_COMMA, cur_pos, next_end());
            "+": push_token(stt_pkg::K_PLUS, cur_pos, next_end());
            "-": push_token(stt_pkg::K_MINUS, cur_pos, next_end());
            "/": push_token(stt_pkg::K_SLASH, cur_pos, next_end());
            "~": push_token(stt_pkg::K_TILDE, cur_pos, next_end());
            "^": push_token(stt_pkg::K_CARET, cur_pos, next_end());
            default: begin
                if (c >= "0" && c <= "9") begin
                    hold(stt_pkg::M_INT);
                end else if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_") begin
                    hold(stt_pkg::M_IDENT);
                    kw_cands = '1;
                    narrow_keywords(c);
                end else begin
                    push_token(stt_pkg::K_ERROR, cur_pos, next_end());
                end
            end
        endcase
        return 1'b0;
    endfunction

    // Advance the predicted scanner by one accepted byte
    function automatic void predict_byte(input logic [7:0] c);
        bit consumed;
        bit ended;
        bit is_digit;
        bit is_word;
        consumed = 1'b0;
        ended    = 1'b0;
        is_digit = (c >= "0" && c <= "9");
        is_word  = is_digit || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
        step_tokens.delete();
        case (scan_mode)
            stt_pkg::M_STAR:    consumed = close_operator(c, "*", stt_pkg::K_POW, CH_NUL,
                                                          stt_pkg::K_POW, stt_pkg::K_STAR);
            stt_pkg::M_GREATER: consumed = close_operator(c, ">", stt_pkg::K_SHR, "=",
                                                          stt_pkg::K_GE, stt_pkg::K_GT);
            stt_pkg::M_LESS:    consumed = close_operator(c, "<", stt_pkg::K_SHL, "=",
                                                          stt_pkg::K_LE, stt_pkg::K_LT);
            stt_pkg::M_EQUAL:   consumed = close_operator(c, "=", stt_pkg::K_EQ, CH_NUL,
                                                          stt_pkg::K_EQ, stt_pkg::K_ASSIGN);
            stt_pkg::M_AMP:     consumed = close_operator(c, "&", stt_pkg::K_LAND, CH_NUL,
                                                          stt_pkg::K_LAND, stt_pkg::K_AMP);
            stt_pkg::M_PIPE:    consumed = close_operator(c, "|", stt_pkg::K_LOR, CH_NUL,
                                                          stt_pkg::K_LOR, stt_pkg::K_PIPE);
            stt_pkg::M_BANG:    consumed = close_operator(c, "=", stt_pkg::K_NE, CH_NUL,
                                                          stt_pkg::K_NE, stt_pkg::K_BANG);
            stt_pkg::M_INT: begin
                if (is_digit) begin
                    consumed = 1'b1;
                end else if (c == ".") begin
                    scan_mode = stt_pkg::M_DEC;
                    consumed  = 1'b1;
                end else begin
                    push_token(stt_pkg::K_INTEGER, tok_begin, cur_pos);
                    scan_mode = stt_pkg::M_IDLE;
                end
            end
            stt_pkg::M_DEC: begin
                if (is_digit) begin
                    consumed = 1'b1;
                end else begin
                    push_token(stt_pkg::K_DECIMAL, tok_begin, cur_pos);
                    scan_mode = stt_pkg::M_IDLE;
                end
            end
            stt_pkg::M_IDENT: begin
                if (is_word) begin
                    narrow_keywords(c);
                    consumed = 1'b1;
                end else begin
                    push_token(identifier_kind(), tok_begin, cur_pos);
                    kw_cands  = '1;
                    scan_mode = stt_pkg::M_IDLE;
                end
            end
            stt_pkg::M_STRING: begin
                consumed = 1'b1;
                if (c == "\"") begin
                    push_token(stt_pkg::K_STRING, tok_begin, next_end());
                    scan_mode = stt_pkg::M_IDLE;
                end else if (c == CH_NUL) begin
                    // unterminated string: error over what was read, then end
                    push_token(stt_pkg::K_ERROR, tok_begin, cur_pos);
                    push_token(stt_pkg::K_END, cur_pos, next_end());
                    ended = 1'b1;
                end
            end
            default: scan_mode = stt_pkg::M_IDLE;
        endcase

        if (!consumed)
            ended = scan_idle(c);

        if (step_tokens.size() > 0)
            step_tokens[step_tokens.size() - 1].last = 1'b1;
        foreach (step_tokens[i])
            due_tokens.push_back(step_tokens[i]);

        if (ended) begin
            reset_scanner();
        end else begin
            if (c == CH_LF && line_cnt < LINE_MAX)
                line_cnt++;
            if (cur_pos < POS_MAX)
                cur_pos++;
        end
    endfunction

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("token %0d: %s is %0d, expected %0d",
                                      tokens_seen, name, got, want));
    endtask

    // Watch both channels: predict on each request, compare each token
    always @(posedge i_clk) begin
        stt_pkg::t_token got;
        stt_pkg::t_token want;
        if (!i_rst_n) begin
            reset_scanner();
            due_tokens.delete();
        end else begin
            if (i_s_tvalid && i_s_tready)
                predict_byte(i_s_tdata);
            if (i_m_tvalid && i_m_tready) begin
                got.kind   = i_m_tdata[5:0];
                got.start  = i_m_tdata[21:6];
                got.length = i_m_tdata[37:22];
                got.line   = i_m_tdata[53:38];
                got.last   = i_m_tlast;
                if (due_tokens.size() == 0) begin
                    report_mismatch($sformatf("token %0d: kind %0d at %0d arrived with none due",
                                              tokens_seen, got.kind, got.start));
                end else begin
                    want = due_tokens.pop_front();
                    check_field("kind", int'(got.kind), int'(want.kind));
                    check_field("start", int'(got.start), int'(want.start));
                    check_field("length", int'(got.length), int'(want.length));
                    check_field("line", int'(got.line), int'(want.line));
                    check_field("last", int'(got.last), int'(want.last));
                end
                tokens_seen++;
            end
        end
        o_pending    <= due_tokens.size();
        o_fail_count <= fail_total;
    end

endmodule

FILE: test/source_text_tokenizer_core_tb.sv
// Top of the source text tokenizer testbench: clock, reset, byte stimulus and verdict.
module source_text_tokenizer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 2000;   // cycles with no transfer on either side
    localparam int TAIL_CYCLES = 8;

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;     // [7:0] ch
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;             // [5:0] kind, [21:6] start, [37:22] length,
                                           // [53:38] line
    logic        m_axis_tlast;             // last

    int fail_count;
    int pending_tokens;
    int quiet_cycles = 0;
    int stall_left = 0;
    int sent_bytes = 0;
    bit sender_idles = 1'b1;
    bit receiver_idles = 1'b1;

    string kw_spelling [10] = '{"let", "return", "function", "if", "else",
                                "while", "for", "in", "continue", "break"};
    string op_spelling [31] = '{"(", ")", "[", "]", "{", "}", ";", ":", ".", ",",
                                "+", "-", "*", "**", "/", ">", ">>", ">=", "<", "<<",
                                "<=", "=", "==", "&", "&&", "|", "||", "~", "!", "!=",
                                "^"};

    always #5 i_clk = ~i_clk;

    source_text_tokenizer_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    source_text_tokenizer_core_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tlast    (m_axis_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending_tokens)
    );

    // Token sink: random stall bursts while enabled
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (receiver_idles && $urandom_range(0, 6) == 0) begin
            stall_left    <= $urandom_range(1, 18) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Watchdog: give up when nothing moves for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("source_text_tokenizer_core: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one byte and hold it until the block takes the request
    task automatic send_byte(input logic [7:0] b);
        if (sender_idles && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        sent_bytes++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // Sender stops and waits until every due token has come out
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_tokens != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [7:0] rand_ident_start();
        int r;
        r = $urandom_range(0, 52);
        if (r < 26)
            return 8'("a" + r);
        if (r < 52)
            return 8'("A" + r - 26);
        return "_";
    endfunction

    function automatic logic [7:0] rand_ident_char();
        int r;
        r = $urandom_range(0, 62);
        if (r < 10)
            return 8'("0" + r);
        return rand_ident_start();
    endfunction

    // One random lexeme, mostly well formed, some noise and broken input
    task automatic send_random_token();
        string w;
        logic [7:0] b;
        case ($urandom_range(0, 19))
            0, 1: begin
                w = kw_spelling[$urandom_range(0, 9)];
                case ($urandom_range(0, 2))
                    0: send_text(w);
                    1: begin
                        send_text(w);
                        send_byte(rand_ident_char());
                    end
                    default: send_text(w.substr(0, w.len() - 2));
                endcase
            end
            2, 3: begin
                send_byte(rand_ident_start());
                repeat ($urandom_range(0, 6)) send_byte(rand_ident_char());
            end
            4, 5: repeat ($urandom_range(1, 5)) send_byte(8'("0" + $urandom_range(0, 9)));
            6: begin
                repeat ($urandom_range(1, 4)) send_byte(8'("0" + $urandom_range(0, 9)));
                send_byte(".");
                repeat ($urandom_range(0, 3)) send_byte(8'("0" + $urandom_range(0, 9)));
            end
            7: begin
                send_byte("\"");
                repeat ($urandom_range(0, 8)) begin
                    b = 8'($urandom_range(1, 255));
                    if (b == "\"")
                        b = CH_LF;
                    send_byte(b);
                end
                send_byte("\"");
            end
            8, 9, 10, 11: send_text(op_spelling[$urandom_range(0, 30)]);
            12, 13: begin
                case ($urandom_range(0, 3))
                    0: send_byte(" ");
                    1: send_byte(CH_TAB);
                    2: send_byte(CH_CR);
                    default: send_byte(CH_LF);
                endcase
            end
            14: send_byte(8'($urandom_range(1, 255)));
            15: send_byte(($urandom_range(0, 2) == 0) ? CH_NUL : " ");
            16: begin
                // string left open at the end of the source
                send_byte("\"");
                repeat ($urandom_range(0, 4)) send_byte(rand_ident_char());
                send_byte(CH_NUL);
            end
            default: send_byte(" ");
        endcase
    endtask

    task automatic run_random(input int count);
        int target;
        target = sent_bytes + count;
        while (sent_bytes < target)
            send_random_token();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: keyword, string over a line break, unknown and top bytes,
        // bare decimal, end of source, open string at the end, paired operators
        send_text("if(a1)");
        send_text("\"s\nt\"");
        send_byte(8'hFF);
        send_byte(8'h01);
        send_text("3.");
        send_byte(CH_NUL);
        send_text("\"ab");
        send_byte(CH_NUL);
        send_text("x**y!=;");

        // Random with gaps on both sides
        run_random(400);
        wait_drained();

        // Sender gaps only, then sink stalls only
        receiver_idles = 1'b0;
        run_random(150);
        sender_idles   = 1'b0;
        receiver_idles = 1'b1;
        run_random(150);

        // End of source, empty string, a keyword, a number, operators, then a string left open at the end
        receiver_idles = 1'b0;
        send_byte(CH_NUL);
        send_byte("\"");
        send_text("\" let 12.5 ** x9 >= \"q");
        send_byte(CH_NUL);

        // Closing stretch with no idling
        run_random(200);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_tokens == 0)
            $display("source_text_tokenizer_core: match");
        else
            $display("source_text_tokenizer_core: mismatch");
        $finish;
    end

endmodule
